// ----- hw/rtl/lflc_pkg.sv -----
`default_nettype none

package lflc_pkg;

    // Mode codes, as reported on mode_now
    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_LEFT     = 3'd1;
    localparam logic [2:0] MODE_RIGHT    = 3'd2;
    localparam logic [2:0] MODE_STRAIGHT = 3'd3;
    localparam logic [2:0] MODE_LANE     = 3'd4;
    localparam logic [2:0] MODE_SIGNAL   = 3'd5;

    // H-bridge pattern: in11 and in22 high
    localparam logic [3:0] BRIDGE_FWD = 4'b1001;
    localparam logic [3:0] BRIDGE_OFF = 4'b0000;

    // Register indexes on the config port
    localparam logic [2:0] REG_SPEED_STRAIGHT = 3'd0;
    localparam logic [2:0] REG_SPEED_INNER    = 3'd1;
    localparam logic [2:0] REG_SPEED_OUTER    = 3'd2;
    localparam logic [2:0] REG_LANE_TICKS     = 3'd3;
    localparam logic [2:0] REG_BEEP_HALF      = 3'd4;
    localparam logic [2:0] REG_BEEP_COUNT     = 3'd5;

    // Duty scaling
    localparam int         DUTY_SCALE = 65536;
    localparam int         PCT_FULL   = 100;
    localparam int         DUTY_MAX   = 65535;
    localparam logic [6:0] PCT_LIMIT  = 7'd100;

    typedef struct packed {
        logic [6:0]  speed_straight;
        logic [6:0]  speed_inner;
        logic [6:0]  speed_outer;
        logic [15:0] lane_change_ticks;
        logic [15:0] beep_half_ticks;
        logic [7:0]  beep_count;
    } cfg_t;

    // Result item; right_duty lands in the low bits
    typedef struct packed {
        logic [2:0]  mode_now;
        logic        buzzer_on;
        logic        led_two;
        logic        led_one;
        logic [3:0]  bridge_pins;
        logic [15:0] left_duty;
        logic [15:0] right_duty;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    typedef logic [15:0] duty_lut_t [0:127];

    // Percent to compare value, worked out at elaboration
    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        longint    v;
        for (int i = 0; i < 128; i++)
        begin
            v = (longint'(i) * DUTY_SCALE) / PCT_FULL;
            if (v > DUTY_MAX)
            begin
                v = DUTY_MAX;
            end
            lut[i] = 16'(v);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

`default_nettype wire

// ----- hw/rtl/lflc_core.sv -----
`default_nettype none

module lflc_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             floor_right,
    input  wire logic             floor_left,
    input  wire logic             bin_right,
    input  wire logic             bin_left,
    input  wire lflc_pkg::cfg_t   cfg,
    output lflc_pkg::result_t     result
);

    logic [2:0]  mode_reg,  mode_next;
    logic [15:0] lane_reg,  lane_next;
    logic [15:0] phase_reg, phase_next;
    logic [8:0]  beeps_reg, beeps_next;
    logic [15:0] right_reg, right_next;
    logic [15:0] left_reg,  left_next;
    logic [3:0]  bridge_reg, bridge_next;
    logic [2:0]  ind_reg,   ind_next;   // bit0 LED1, bit1 LED2, bit2 buzzer

    logic        both_on, both_off, trig, enter_sig;
    logic [2:0]  mode_cur;
    logic [15:0] phase_cur, phase_inc, lane_inc;
    logic [8:0]  beeps_cur, beeps_inc, halves;
    logic [15:0] lane_lim, half_lim;
    logic [7:0]  count_eff;
    logic [6:0]  rpct, lpct;
    logic        rset, lset;

    assign both_on  = !floor_right && !floor_left;
    assign both_off = floor_right && floor_left;
    assign trig     = !bin_right || !bin_left;

    // A bin sensor pulls the machine into the signal sequence at once
    assign enter_sig = (mode_reg != lflc_pkg::MODE_SIGNAL) && trig;
    assign mode_cur  = enter_sig ? lflc_pkg::MODE_SIGNAL : mode_reg;
    assign phase_cur = enter_sig ? 16'd0 : phase_reg;
    assign beeps_cur = enter_sig ? 9'd0 : beeps_reg;

    // Zero counts behave as one
    assign lane_lim  = (cfg.lane_change_ticks == 16'd0) ? 16'd1 : cfg.lane_change_ticks;
    assign half_lim  = (cfg.beep_half_ticks == 16'd0) ? 16'd1 : cfg.beep_half_ticks;
    assign count_eff = (cfg.beep_count == 8'd0) ? 8'd1 : cfg.beep_count;
    assign halves    = {count_eff, 1'b0};

    assign lane_inc  = lane_reg + 16'd1;
    assign phase_inc = phase_cur + 16'd1;
    assign beeps_inc = beeps_cur + 9'd1;

    // Mode behavior
    always_comb
    begin
        mode_next   = mode_cur;
        lane_next   = lane_reg;
        phase_next  = phase_cur;
        beeps_next  = beeps_cur;
        bridge_next = bridge_reg;
        ind_next    = ind_reg;
        rpct        = cfg.speed_straight;
        lpct        = cfg.speed_straight;
        rset        = 1'b0;
        lset        = 1'b0;
        case (mode_cur)
            lflc_pkg::MODE_START:
            begin
                rset        = 1'b1;
                lset        = 1'b1;
                bridge_next = lflc_pkg::BRIDGE_FWD;
                if (both_on)
                begin
                    mode_next = lflc_pkg::MODE_STRAIGHT;
                end
            end
            lflc_pkg::MODE_LEFT, lflc_pkg::MODE_RIGHT:
            begin
                rset = 1'b1;
                lset = 1'b1;
                if (mode_cur == lflc_pkg::MODE_LEFT)
                begin
                    rpct = cfg.speed_inner;
                    lpct = cfg.speed_outer;
                end
                else
                begin
                    rpct = cfg.speed_outer;
                    lpct = cfg.speed_inner;
                end
                if (both_on)
                begin
                    mode_next = lflc_pkg::MODE_STRAIGHT;
                end
                else if (both_off)
                begin
                    mode_next = lflc_pkg::MODE_LANE;
                end
            end
            lflc_pkg::MODE_STRAIGHT:
            begin
                rset        = 1'b1;
                lset        = 1'b1;
                bridge_next = lflc_pkg::BRIDGE_FWD;
                if (floor_right)
                begin
                    mode_next = lflc_pkg::MODE_LEFT;
                end
                else if (floor_left)
                begin
                    mode_next = lflc_pkg::MODE_RIGHT;
                end
            end
            lflc_pkg::MODE_LANE:
            begin
                rpct = cfg.speed_inner;
                lpct = cfg.speed_outer;
                if (lane_inc >= lane_lim)
                begin
                    lane_next = 16'd0;
                    rset      = 1'b1;
                    lset      = 1'b1;
                    if (both_on)
                    begin
                        mode_next = lflc_pkg::MODE_STRAIGHT;
                    end
                end
                else
                begin
                    lane_next = lane_inc;
                end
            end
            default:
            begin
                // Signal: odd half beeps light LED2 only
                bridge_next = lflc_pkg::BRIDGE_OFF;
                ind_next    = beeps_cur[0] ? 3'b010 : 3'b101;
                if (phase_inc >= half_lim)
                begin
                    phase_next = 16'd0;
                    if (beeps_inc >= halves)
                    begin
                        beeps_next = 9'd0;
                        mode_next  = lflc_pkg::MODE_STRAIGHT;
                    end
                    else
                    begin
                        beeps_next = beeps_inc;
                    end
                end
                else
                begin
                    phase_next = phase_inc;
                end
            end
        endcase
    end

    // Duty update; a percent over the limit leaves the register alone
    assign right_next = (rset && (rpct <= lflc_pkg::PCT_LIMIT)) ?
                        lflc_pkg::DUTY_LUT[rpct] : right_reg;
    assign left_next  = (lset && (lpct <= lflc_pkg::PCT_LIMIT)) ?
                        lflc_pkg::DUTY_LUT[lpct] : left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lflc_pkg::MODE_START;
            lane_reg   <= 16'd0;
            phase_reg  <= 16'd0;
            beeps_reg  <= 9'd0;
            right_reg  <= 16'd0;
            left_reg   <= 16'd0;
            bridge_reg <= lflc_pkg::BRIDGE_OFF;
            ind_reg    <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            lane_reg   <= lane_next;
            phase_reg  <= phase_next;
            beeps_reg  <= beeps_next;
            right_reg  <= right_next;
            left_reg   <= left_next;
            bridge_reg <= bridge_next;
            ind_reg    <= ind_next;
        end
    end

    // Result of this beat: state after the update, mode that ran
    always_comb
    begin
        result.mode_now    = mode_cur;
        result.buzzer_on   = ind_next[2];
        result.led_two     = ind_next[1];
        result.led_one     = ind_next[0];
        result.bridge_pins = bridge_next;
        result.left_duty   = left_next;
        result.right_duty  = right_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/line_follower_lane_controller.sv -----
`default_nettype none

// Channel  Dir  Beat fields
// s_*      in   s_tdata[3:0]: floor_right, floor_left, bin_right, bin_left
// m_*      out  m_tdata[41:0]: right_duty, left_duty, bridge_pins, led_one,
//                             led_two, buzzer_on, mode_now
// APB      in   six registers at byte addresses 0x00..0x14
//
// One beat per clock in and one result beat per clock out while m_tready stays high;
// the whole tick is evaluated between the state registers and the output register.
// Results pass through an output register backed by a one-entry skid, so an
// input beat is still taken while one result waits.
// s_tready drops only while the skid holds a result.
// Reset puts the controller in start mode with duties, pins and LEDs at zero.

module line_follower_lane_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // floor_right, floor_left, bin_right, bin_left
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // right_duty, left_duty, bridge_pins, led_one,
                                        // led_two, buzzer_on, mode_now
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    lflc_pkg::cfg_t    cfg_reg;
    lflc_pkg::result_t result;
    lflc_pkg::result_t out_data_reg, skid_data_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              in_accept, out_pop, cfg_write;
    logic [2:0]        reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[4:2];

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_straight    <= 7'd70;
            cfg_reg.speed_inner       <= 7'd65;
            cfg_reg.speed_outer       <= 7'd75;
            cfg_reg.lane_change_ticks <= 16'd15000;
            cfg_reg.beep_half_ticks   <= 16'd500;
            cfg_reg.beep_count        <= 8'd10;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                lflc_pkg::REG_SPEED_STRAIGHT: cfg_reg.speed_straight    <= pwdata[6:0];
                lflc_pkg::REG_SPEED_INNER:    cfg_reg.speed_inner       <= pwdata[6:0];
                lflc_pkg::REG_SPEED_OUTER:    cfg_reg.speed_outer       <= pwdata[6:0];
                lflc_pkg::REG_LANE_TICKS:     cfg_reg.lane_change_ticks <= pwdata[15:0];
                lflc_pkg::REG_BEEP_HALF:      cfg_reg.beep_half_ticks   <= pwdata[15:0];
                lflc_pkg::REG_BEEP_COUNT:     cfg_reg.beep_count        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            lflc_pkg::REG_SPEED_STRAIGHT: prdata = {25'd0, cfg_reg.speed_straight};
            lflc_pkg::REG_SPEED_INNER:    prdata = {25'd0, cfg_reg.speed_inner};
            lflc_pkg::REG_SPEED_OUTER:    prdata = {25'd0, cfg_reg.speed_outer};
            lflc_pkg::REG_LANE_TICKS:     prdata = {16'd0, cfg_reg.lane_change_ticks};
            lflc_pkg::REG_BEEP_HALF:      prdata = {16'd0, cfg_reg.beep_half_ticks};
            lflc_pkg::REG_BEEP_COUNT:     prdata = {24'd0, cfg_reg.beep_count};
            default:                      prdata = 32'd0;
        endcase
    end

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_pop   = out_valid_reg && m_tready;

    lflc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .floor_right (s_tdata[0]),
        .floor_left  (s_tdata[1]),
        .bin_right   (s_tdata[2]),
        .bin_left    (s_tdata[3]),
        .cfg         (cfg_reg),
        .result      (result)
    );

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_accept)
            begin
                out_data_reg <= result;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(lflc_pkg::OUT_TDATA_W - lflc_pkg::RESULT_W)'(0), out_data_reg};

`ifndef SYNTH
    // The skid never holds a beat while the output register is empty
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat with output register empty");

    // A beat taken while the output is stalled goes into the skid
    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("beat accepted under stall was not parked");

    // A waiting result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Output drains from the skid once the output moves
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_pop && skid_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid did not move to output");
`endif

endmodule

`default_nettype wire

// ----- tb/line_follower_lane_controller_test.sv -----
`default_nettype none

module line_follower_lane_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_TAIL  = 16;
    localparam int MAX_PRINTS  = 30;

    // DUT ports; the inputs that the bench drives are known from time zero
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h0F;   // floor_right, floor_left, bin_right, bin_left
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;            // right_duty, left_duty, bridge_pins, led_one,
                                     // led_two, buzzer_on, mode_now
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Sensor nibbles waiting to go out, results waiting to come back
    logic [3:0]        sensor_beats[$];
    lflc_pkg::result_t pending_results[$];

    // Controller copy: settings and state
    lflc_pkg::cfg_t cfg_now;
    logic [2:0]  ctl_mode     = lflc_pkg::MODE_START;
    logic [15:0] lane_count   = 16'd0;
    logic [15:0] beep_timer   = 16'd0;
    logic [8:0]  halves_done  = 9'd0;
    logic [15:0] right_duty_q = 16'd0;
    logic [15:0] left_duty_q  = 16'd0;
    logic [3:0]  bridge_q     = lflc_pkg::BRIDGE_OFF;
    logic [2:0]  lamp_q       = 3'b000;   // {buzzer, led2, led1}

    // Bookkeeping
    int   beats_queued  = 0;
    int   beats_taken   = 0;
    int   beats_checked = 0;
    int   signal_runs   = 0;
    int   lane_updates  = 0;
    int   settings_used = 0;
    int   error_count   = 0;
    int   quiet_cycles  = 0;
    int   feed_gap      = 0;
    int   stall_left    = 0;
    logic no_idle       = 1'b0;

    line_follower_lane_controller i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // Idle length: mostly short, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(9, 0) < 8)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 4);
    endfunction

    // Percent to compare value; out-of-range percent keeps the old value
    function automatic logic [15:0] duty_of(input logic [6:0] pct, input logic [15:0] held);
        int scaled;
        if (pct > lflc_pkg::PCT_LIMIT)
        begin
            return held;
        end
        scaled = int'(pct) * lflc_pkg::DUTY_SCALE / lflc_pkg::PCT_FULL;
        if (scaled > lflc_pkg::DUTY_MAX)
        begin
            scaled = lflc_pkg::DUTY_MAX;
        end
        return 16'(scaled);
    endfunction

    // Advance the controller copy by one tick, give the result beat
    function automatic lflc_pkg::result_t predict_tick(input logic [3:0] sens);
        logic              fr_off;
        logic              fl_off;
        logic              both_on;
        logic              both_off;
        logic [15:0]       lim;
        logic [15:0]       half;
        logic [8:0]        halves;
        lflc_pkg::result_t r;
        fr_off   = sens[0];
        fl_off   = sens[1];
        both_on  = !fr_off && !fl_off;
        both_off = fr_off && fl_off;

        // Bin sensor trigger, ignored while a signal runs
        if (ctl_mode != lflc_pkg::MODE_SIGNAL && (!sens[2] || !sens[3]))
        begin
            ctl_mode    = lflc_pkg::MODE_SIGNAL;
            beep_timer  = 16'd0;
            halves_done = 9'd0;
            signal_runs++;
        end
        r.mode_now = ctl_mode;

        case (ctl_mode)
            lflc_pkg::MODE_START:
            begin
                right_duty_q = duty_of(cfg_now.speed_straight, right_duty_q);
                left_duty_q  = duty_of(cfg_now.speed_straight, left_duty_q);
                bridge_q     = lflc_pkg::BRIDGE_FWD;
                if (both_on)
                begin
                    ctl_mode = lflc_pkg::MODE_STRAIGHT;
                end
            end
            lflc_pkg::MODE_LEFT, lflc_pkg::MODE_RIGHT:
            begin
                if (ctl_mode == lflc_pkg::MODE_LEFT)
                begin
                    right_duty_q = duty_of(cfg_now.speed_inner, right_duty_q);
                    left_duty_q  = duty_of(cfg_now.speed_outer, left_duty_q);
                end
                else
                begin
                    right_duty_q = duty_of(cfg_now.speed_outer, right_duty_q);
                    left_duty_q  = duty_of(cfg_now.speed_inner, left_duty_q);
                end
                if (both_on)
                begin
                    ctl_mode = lflc_pkg::MODE_STRAIGHT;
                end
                else if (both_off)
                begin
                    ctl_mode = lflc_pkg::MODE_LANE;
                end
            end
            lflc_pkg::MODE_STRAIGHT:
            begin
                bridge_q     = lflc_pkg::BRIDGE_FWD;
                right_duty_q = duty_of(cfg_now.speed_straight, right_duty_q);
                left_duty_q  = duty_of(cfg_now.speed_straight, left_duty_q);
                if (fr_off)
                begin
                    ctl_mode = lflc_pkg::MODE_LEFT;
                end
                else if (fl_off)
                begin
                    ctl_mode = lflc_pkg::MODE_RIGHT;
                end
            end
            lflc_pkg::MODE_LANE:
            begin
                lim = (cfg_now.lane_change_ticks == 16'd0) ? 16'd1 : cfg_now.lane_change_ticks;
                lane_count = lane_count + 16'd1;
                if (lane_count >= lim)
                begin
                    lane_count   = 16'd0;
                    right_duty_q = duty_of(cfg_now.speed_inner, right_duty_q);
                    left_duty_q  = duty_of(cfg_now.speed_outer, left_duty_q);
                    lane_updates++;
                    if (both_on)
                    begin
                        ctl_mode = lflc_pkg::MODE_STRAIGHT;
                    end
                end
            end
            default:
            begin
                // Signal: LED1 and buzzer on the even halves, LED2 on the odd ones
                half   = (cfg_now.beep_half_ticks == 16'd0) ? 16'd1 : cfg_now.beep_half_ticks;
                halves = (cfg_now.beep_count == 8'd0) ? 9'd2 : {cfg_now.beep_count, 1'b0};
                bridge_q   = lflc_pkg::BRIDGE_OFF;
                lamp_q     = halves_done[0] ? 3'b010 : 3'b101;
                beep_timer = beep_timer + 16'd1;
                if (beep_timer >= half)
                begin
                    beep_timer  = 16'd0;
                    halves_done = halves_done + 9'd1;
                    if (halves_done >= halves)
                    begin
                        halves_done = 9'd0;
                        ctl_mode    = lflc_pkg::MODE_STRAIGHT;
                    end
                end
            end
        endcase

        r.right_duty  = right_duty_q;
        r.left_duty   = left_duty_q;
        r.bridge_pins = bridge_q;
        r.led_one     = lamp_q[0];
        r.led_two     = lamp_q[1];
        r.buzzer_on   = lamp_q[2];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
        begin
            $display("%0t: MISMATCH %s", $realtime, what);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("beat %0d %s got 0x%0h want 0x%0h",
                                      beats_checked, name, got, want));
        end
    endtask

    // Sensor driver: one beat held until taken, random gaps between beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(predict_tick(s_tdata[3:0]));
                beats_taken++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (sensor_beats.size() > 0)
                begin
                    s_tdata  <= {4'b0000, sensor_beats.pop_front()};
                    s_tvalid <= 1'b1;
                    feed_gap = (no_idle || $urandom_range(1, 0) == 0) ? 0 : idle_len();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result beat 0x%0h with nothing expected",
                                              m_tdata));
                end
                else
                begin
                    lflc_pkg::result_t want;
                    lflc_pkg::result_t got;
                    want = pending_results.pop_front();
                    got  = m_tdata[lflc_pkg::RESULT_W-1:0];
                    check_field("right_duty", got.right_duty, want.right_duty);
                    check_field("left_duty", got.left_duty, want.left_duty);
                    check_field("bridge_pins", 16'(got.bridge_pins), 16'(want.bridge_pins));
                    check_field("led_one", 16'(got.led_one), 16'(want.led_one));
                    check_field("led_two", 16'(got.led_two), 16'(want.led_two));
                    check_field("buzzer_on", 16'(got.buzzer_on), 16'(want.buzzer_on));
                    check_field("mode_now", 16'(got.mode_now), 16'(want.mode_now));
                    beats_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(3, 0) == 0)
                begin
                    stall_left = idle_len();
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("line_follower_lane_controller_test: errors");
                $finish;
            end
        end
    end

    // APB write: setup cycle, access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lflc_pkg::REG_SPEED_STRAIGHT: cfg_now.speed_straight    = value[6:0];
            lflc_pkg::REG_SPEED_INNER:    cfg_now.speed_inner       = value[6:0];
            lflc_pkg::REG_SPEED_OUTER:    cfg_now.speed_outer       = value[6:0];
            lflc_pkg::REG_LANE_TICKS:     cfg_now.lane_change_ticks = value[15:0];
            lflc_pkg::REG_BEEP_HALF:      cfg_now.beep_half_ticks   = value[15:0];
            lflc_pkg::REG_BEEP_COUNT:     cfg_now.beep_count        = value[7:0];
            default: ;
        endcase
    endtask

    task automatic program_all(input int straight, input int inner, input int outer,
                               input int lane, input int half, input int beeps);
        write_reg(lflc_pkg::REG_SPEED_STRAIGHT, straight);
        write_reg(lflc_pkg::REG_SPEED_INNER, inner);
        write_reg(lflc_pkg::REG_SPEED_OUTER, outer);
        write_reg(lflc_pkg::REG_LANE_TICKS, lane);
        write_reg(lflc_pkg::REG_BEEP_HALF, half);
        write_reg(lflc_pkg::REG_BEEP_COUNT, beeps);
        settings_used++;
    endtask

    // Nibble order {bin_left, bin_right, floor_left, floor_right}, 0 = active
    task automatic queue_beat(input logic [3:0] sens);
        sensor_beats.push_back(sens);
        beats_queued++;
    endtask

    // Runs of held floor patterns, bin triggers at the given percent
    task automatic queue_drive(input int n, input int trig_pct);
        logic [1:0] floor_bits;
        logic [1:0] bin_bits;
        int         k;
        k = 0;
        while (k < n)
        begin
            floor_bits = 2'($urandom_range(3, 0));
            repeat ($urandom_range(6, 1))
            begin
                bin_bits = ($urandom_range(99, 0) < trig_pct) ?
                           2'($urandom_range(2, 0)) : 2'b11;
                queue_beat({bin_bits, floor_bits});
                k++;
            end
        end
    endtask

    task automatic wait_idle();
        while (!(beats_taken == beats_queued && pending_results.size() == 0))
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        cfg_now.speed_straight    = 7'd70;
        cfg_now.speed_inner       = 7'd65;
        cfg_now.speed_outer       = 7'd75;
        cfg_now.lane_change_ticks = 16'd15000;
        cfg_now.beep_half_ticks   = 16'd500;
        cfg_now.beep_count        = 8'd10;
        settings_used = 1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: walk the driving modes into lane change
        queue_beat(4'b1111);
        queue_beat(4'b1110);
        queue_beat(4'b1100);
        queue_beat(4'b1101);
        queue_beat(4'b1101);
        queue_beat(4'b1100);
        queue_beat(4'b1110);
        queue_beat(4'b1111);
        queue_beat(4'b1111);
        queue_beat(4'b1100);
        wait_idle();

        // Full, zero and over-range percents; zero ticks and zero beep count
        program_all(100, 0, 127, 0, 0, 0);
        queue_beat(4'b1100);
        queue_beat(4'b1111);
        queue_beat(4'b1011);
        queue_beat(4'b0011);
        queue_beat(4'b1100);
        queue_beat(4'b0100);
        queue_beat(4'b0000);
        queue_beat(4'b1101);
        queue_beat(4'b1111);
        queue_beat(4'b1110);
        queue_beat(4'b1100);
        queue_beat(4'b1111);
        wait_idle();

        // Longest tick counts, just over the percent limit
        program_all(101, 100, 0, 65535, 65535, 1);
        queue_drive(60, 3);
        wait_idle();

        // Largest beep count, no idling at all
        no_idle = 1'b1;
        program_all($urandom_range(127, 0), $urandom_range(127, 0), $urandom_range(127, 0),
                    2, 1, 255);
        queue_drive(150, 4);
        wait_idle();
        no_idle = 1'b0;

        // Random settings with short counts
        for (int p = 0; p < 7; p++)
        begin
            no_idle = (p == 3);
            program_all($urandom_range(127, 0), $urandom_range(127, 0),
                        $urandom_range(127, 0), $urandom_range(6, 0),
                        $urandom_range(5, 0), $urandom_range(5, 0));
            queue_drive(100, 6);
            wait_idle();
        end
        no_idle = 1'b0;

        repeat (DRAIN_TAIL) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("Checked %0d result beats over %0d register settings.",
                 beats_checked, settings_used);
        $display("Signal sequences started: %0d, lane-change updates: %0d, mismatches: %0d.",
                 signal_runs, lane_updates, error_count);
        if (error_count == 0)
        begin
            $display("line_follower_lane_controller_test: clean");
        end
        else
        begin
            $display("line_follower_lane_controller_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- line_follower_lane_controller.f -----
hw/rtl/lflc_pkg.sv
hw/rtl/lflc_core.sv
hw/rtl/line_follower_lane_controller.sv
tb/line_follower_lane_controller_test.sv
